[rtl/iefa_pkg.sv]
package iefa_pkg;

	localparam logic [4:0] TYPE_SYN = 5'd0;
	localparam logic [4:0] TYPE_KEY = 5'd1;
	localparam logic [4:0] TYPE_REL = 5'd2;
	localparam logic [4:0] TYPE_ABS = 5'd3;

	localparam logic [9:0] SYNC_REPORT  = 10'd0;
	localparam logic [9:0] BUTTON_MOUSE = 10'd272;
	localparam logic [9:0] BUTTON_TOUCH = 10'd330;
	localparam logic [9:0] CODE_HOME    = 10'd102;
	localparam logic [9:0] CODE_MENU    = 10'd139;
	localparam logic [9:0] AXIS_X       = 10'd0;
	localparam logic [9:0] AXIS_Y       = 10'd1;

	localparam logic [2:0] KIND_BTN_DOWN = 3'd0;
	localparam logic [2:0] KIND_BTN_UP   = 3'd1;
	localparam logic [2:0] KIND_MOVE_ABS = 3'd2;
	localparam logic [2:0] KIND_MOVE_REL = 3'd3;
	localparam logic [2:0] KIND_KEY_DOWN = 3'd4;
	localparam logic [2:0] KIND_KEY_UP   = 3'd5;

	typedef struct packed {
		logic [4:0]         ev_type;
		logic [9:0]         ev_code;
		logic signed [31:0] ev_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         event_kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [9:0]         key_id;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic               btn_down;
		logic               btn_up;
		logic               move;
		logic               move_abs;
		logic               key;
		logic               key_press;
		logic [9:0]         key_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} frame_cmd_t;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [31:0] s;
		s = a + b;
		if (a[31] == b[31] && s[31] != a[31]) begin
			s = a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return s;
	endfunction

endpackage

[rtl/iefa_front.sv]
module iefa_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 quirk,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  iefa_pkg::in_item_t   in_data,
	output logic                 push,
	output iefa_pkg::frame_cmd_t push_data,
	input  logic                 full
);

	logic signed [31:0] rel_x_q, rel_y_q, staged_x_q, staged_y_q, shown_x_q, shown_y_q;
	logic touch_q, abs_pend_q, press_q, release_q;

	logic signed [31:0] rel_x_d, rel_y_d, staged_x_d, staged_y_d, shown_x_d, shown_y_d;
	logic touch_d, abs_pend_d, press_d, release_d;
	iefa_pkg::frame_cmd_t cmd;
	logic accept;
	logic nd;

	assign in_ready = !full;
	assign accept = in_valid && !full;

	always_comb begin
		rel_x_d = rel_x_q;
		rel_y_d = rel_y_q;
		staged_x_d = staged_x_q;
		staged_y_d = staged_y_q;
		shown_x_d = shown_x_q;
		shown_y_d = shown_y_q;
		touch_d = touch_q;
		abs_pend_d = abs_pend_q;
		press_d = press_q;
		release_d = release_q;
		cmd = '0;
		nd = in_data.ev_value != 32'sd0;
		case (in_data.ev_type)
			iefa_pkg::TYPE_SYN: begin
				if (in_data.ev_code == iefa_pkg::SYNC_REPORT) begin
					cmd.btn_down = press_q;
					cmd.btn_up = release_q;
					press_d = 1'b0;
					release_d = 1'b0;
					if (quirk && release_q) begin
						abs_pend_d = 1'b0;
						staged_x_d = shown_x_q;
						staged_y_d = shown_y_q;
					end
					if (abs_pend_d) begin
						abs_pend_d = 1'b0;
						shown_x_d = staged_x_d;
						shown_y_d = staged_y_d;
						cmd.move = 1'b1;
						cmd.move_abs = 1'b1;
						cmd.pos_x = staged_x_d;
						cmd.pos_y = staged_y_d;
					end else if (rel_x_q != 32'sd0 || rel_y_q != 32'sd0) begin
						cmd.move = 1'b1;
						cmd.pos_x = rel_x_q;
						cmd.pos_y = rel_y_q;
						rel_x_d = '0;
						rel_y_d = '0;
					end
				end
			end
			iefa_pkg::TYPE_KEY: begin
				if (in_data.ev_code == iefa_pkg::BUTTON_TOUCH ||
						in_data.ev_code == iefa_pkg::BUTTON_MOUSE) begin
					if (nd != touch_q) begin
						touch_d = nd;
						if (nd) begin
							press_d = 1'b1;
						end else begin
							release_d = 1'b1;
						end
					end
				end else begin
					cmd.key = 1'b1;
					cmd.key_press = nd;
					cmd.key_id = (quirk && in_data.ev_code == iefa_pkg::CODE_HOME) ?
						iefa_pkg::CODE_MENU : in_data.ev_code;
				end
			end
			iefa_pkg::TYPE_ABS: begin
				abs_pend_d = 1'b1;
				if (in_data.ev_code == iefa_pkg::AXIS_X) begin
					staged_x_d = in_data.ev_value;
				end else if (in_data.ev_code == iefa_pkg::AXIS_Y) begin
					staged_y_d = in_data.ev_value;
				end
			end
			iefa_pkg::TYPE_REL: begin
				if (in_data.ev_code == iefa_pkg::AXIS_X) begin
					rel_x_d = iefa_pkg::sat_add(rel_x_q, in_data.ev_value);
				end else if (in_data.ev_code == iefa_pkg::AXIS_Y) begin
					rel_y_d = iefa_pkg::sat_add(rel_y_q, in_data.ev_value);
				end
			end
			default: begin
			end
		endcase
	end

	assign push = accept && (cmd.btn_down || cmd.btn_up || cmd.move || cmd.key);
	assign push_data = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_x_q <= '0;
			rel_y_q <= '0;
			staged_x_q <= '0;
			staged_y_q <= '0;
			shown_x_q <= '0;
			shown_y_q <= '0;
			touch_q <= 1'b0;
			abs_pend_q <= 1'b0;
			press_q <= 1'b0;
			release_q <= 1'b0;
		end else if (accept) begin
			rel_x_q <= rel_x_d;
			rel_y_q <= rel_y_d;
			staged_x_q <= staged_x_d;
			staged_y_q <= staged_y_d;
			shown_x_q <= shown_x_d;
			shown_y_q <= shown_y_d;
			touch_q <= touch_d;
			abs_pend_q <= abs_pend_d;
			press_q <= press_d;
			release_q <= release_d;
		end
	end

endmodule

[rtl/iefa_queue.sv]
module iefa_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  iefa_pkg::frame_cmd_t push_data,
	output logic                 full,
	input  logic                 pop,
	output iefa_pkg::frame_cmd_t pop_data,
	output logic                 empty
);

	iefa_pkg::frame_cmd_t slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[rtl/iefa_back.sv]
module iefa_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  iefa_pkg::frame_cmd_t pop_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output iefa_pkg::out_item_t  out_data
);

	iefa_pkg::frame_cmd_t cur_q;
	logic [3:0]           pend_q;
	logic                 out_valid_q;
	iefa_pkg::out_item_t  out_q;

	logic [3:0]          first;
	logic [3:0]          rest;
	logic                out_free;
	logic                adv;
	iefa_pkg::out_item_t res;

	assign out_free = !out_valid_q || out_ready;
	assign adv = out_free && (pend_q != 4'd0);

	always_comb begin
		first = '0;
		if (pend_q[0]) begin
			first[0] = 1'b1;
		end else if (pend_q[1]) begin
			first[1] = 1'b1;
		end else if (pend_q[2]) begin
			first[2] = 1'b1;
		end else if (pend_q[3]) begin
			first[3] = 1'b1;
		end
		rest = pend_q & ~first;
		res = '0;
		res.last = rest == 4'd0;
		if (first[0]) begin
			res.event_kind = iefa_pkg::KIND_BTN_DOWN;
		end else if (first[1]) begin
			res.event_kind = iefa_pkg::KIND_BTN_UP;
		end else if (first[2]) begin
			res.event_kind = cur_q.move_abs ? iefa_pkg::KIND_MOVE_ABS : iefa_pkg::KIND_MOVE_REL;
			res.pos_x = cur_q.pos_x;
			res.pos_y = cur_q.pos_y;
		end else begin
			res.event_kind = cur_q.key_press ? iefa_pkg::KIND_KEY_DOWN : iefa_pkg::KIND_KEY_UP;
			res.key_id = cur_q.key_id;
		end
	end

	assign pop = !empty && ((pend_q == 4'd0) || (adv && rest == 4'd0));

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
		if (adv) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pend_q <= {pop_data.key, pop_data.move, pop_data.btn_up, pop_data.btn_down};
			end else if (adv) begin
				pend_q <= rest;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

[rtl/input_event_frame_assembler_top.sv]
// Channel  Direction  Signals                        Payload
// input    in         in_valid, in_ready, in_data    ev_type, ev_code, ev_value
// output   out        out_valid, out_ready, out_data event_kind, pos_x, pos_y, key_id, last
// config   in         cfg_we, cfg_wdata              release_snap_quirk
//
// An input event is taken whenever the two-entry command queue has room.
// The back end sends one result per cycle while out_ready is high, one after another for a report
// that yields several; results pass through the queue, the command register and the output register.
// Reset clears all frame state, empties the queue and drops out_valid; out_data is not reset.
// A stalled output fills the queue, after which in_ready drops.
module input_event_frame_assembler_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  iefa_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output iefa_pkg::out_item_t out_data
);

	logic                 quirk_q;
	logic                 push, pop, full, empty;
	iefa_pkg::frame_cmd_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quirk_q <= 1'b0;
		end else if (cfg_we) begin
			quirk_q <= cfg_wdata;
		end
	end

	iefa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.quirk     (quirk_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	iefa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	iefa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
